@@ rtl/assert_macros.svh @@
// assertion macros shared by the register bank rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define SPR_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("spr assertion failed");

// when ante holds, cons must hold at the next clock edge
`define SPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spr assertion failed");

`endif

@@ rtl/spr_pkg.sv @@
// types and constants for the system-port register bank
// no dependencies; imported by spr_bank and the top level
`default_nettype none

package spr_pkg;

    localparam int PORT_W = 9;

    // port addresses
    localparam logic [PORT_W-1:0] PORT_CALENDAR = 9'h010;
    localparam logic [PORT_W-1:0] PORT_MASK     = 9'h032;
    localparam logic [PORT_W-1:0] PORT_STROBE   = 9'h040;
    localparam logic [PORT_W-1:0] PORT_MODE_LO  = 9'h150;
    localparam logic [PORT_W-1:0] PORT_MODE_HI  = 9'h151;
    localparam logic [PORT_W-1:0] PORT_AUDIO    = 9'h190;
    localparam logic [PORT_W-1:0] PORT_MODE_SW  = 9'h1c6;
    localparam logic [PORT_W-1:0] PORT_STATUS_A = 9'h1c9;
    localparam logic [PORT_W-1:0] PORT_SERIAL   = 9'h1cb;
    localparam logic [PORT_W-1:0] PORT_CTRL_C   = 9'h1cd;
    localparam logic [PORT_W-1:0] PORT_BSR      = 9'h1cf;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // masks and reset values
    localparam logic [7:0]  MASK_WR_MASK   = 8'hbf;
    localparam logic [7:0]  MASK_RD_MASK   = 8'h7f;
    localparam logic [7:0]  AUDIO_MASK     = 8'h1d;
    localparam logic [15:0] MODE_SW_SET    = 16'hfffe;
    localparam logic [15:0] MODE_SW_CLR    = 16'hfffd;
    localparam logic [7:0]  STROBE_RD_BASE = 8'hc1;
    localparam logic [7:0]  BSR_CMD_MASK   = 8'hf0;
    localparam logic [7:0]  UNMAPPED_RD    = 8'hff;
    localparam logic [7:0]  AUDIO_RESET    = 8'h18;
    localparam logic [7:0]  STATUS_A_RESET = 8'hc1;
    localparam logic [7:0]  CTRL_C_RESET   = 8'hf9;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic              kind;
        logic [PORT_W-1:0] port_address;
        logic [7:0]        write_data;
        logic              vsync_flag;
        logic              calendar_in;
        logic              crt_low_freq;
        logic [7:0]        serial_status;
        logic              fm_mask_in;
    } spr_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [5:0] calendar_lines;
        logic       calendar_update;
        logic       fm_mask_value;
        logic       fm_mask_update;
        logic       mouse_strobe;
        logic       mouse_strobe_update;
        logic       serial_send;
        logic       beep_update;
        logic [2:0] led_state;
        logic [3:0] port_c_low;
    } spr_res_t;

endpackage

`default_nettype wire

@@ rtl/spr_bank.sv @@
// system-port register state, access decode and result formation
// depends on spr_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module spr_bank
    import spr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire spr_req_t req,
    output spr_res_t      res
);

    logic [7:0]  calendar_reg, calendar_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  strobe_reg, strobe_next;
    logic [7:0]  audio_reg, audio_next;
    logic [15:0] mode_sw_reg, mode_sw_next;
    logic [7:0]  status_a_reg, status_a_next;
    logic [7:0]  ctrl_c_reg, ctrl_c_next;

    logic       wr;
    logic [7:0] rd;
    logic       cal_up, fm_up, ms_up, send, beep;
    logic [2:0] bsr_pos;
    logic [2:0] lamp_raw;
    logic       mode_sw_legal;

    assign wr      = (req.kind == KIND_WRITE);
    assign bsr_pos = req.write_data[3:1];

    always_comb begin
        calendar_next = calendar_reg;
        mask_next     = mask_reg;
        strobe_next   = strobe_reg;
        audio_next    = audio_reg;
        mode_sw_next  = mode_sw_reg;
        status_a_next = status_a_reg;
        ctrl_c_next   = ctrl_c_reg;
        rd     = 8'h00;
        cal_up = 1'b0;
        fm_up  = 1'b0;
        ms_up  = 1'b0;
        send   = 1'b0;
        beep   = 1'b0;
        if (wr) begin
            unique case (req.port_address)
                PORT_CALENDAR: begin
                    calendar_next = req.write_data;
                    cal_up        = 1'b1;
                end
                PORT_MASK: begin
                    mask_next = req.write_data & MASK_WR_MASK;
                    fm_up     = 1'b1;
                end
                PORT_STROBE: begin
                    strobe_next = req.write_data;
                    cal_up      = 1'b1;
                    ms_up       = 1'b1;
                end
                PORT_AUDIO: begin
                    audio_next = req.write_data & AUDIO_MASK;
                end
                PORT_MODE_SW: begin
                    mode_sw_next     = req.write_data[0] ? MODE_SW_SET : MODE_SW_CLR;
                    status_a_next[5] = req.write_data[1];
                end
                PORT_CTRL_C: begin
                    send        = ctrl_c_reg[2] ^ req.write_data[2];
                    ctrl_c_next = req.write_data;
                    beep        = 1'b1;
                end
                PORT_BSR: begin
                    // 8255 bit set/reset: only commands with a clear upper nibble
                    if ((req.write_data & BSR_CMD_MASK) == 8'h00) begin
                        ctrl_c_next[bsr_pos] = req.write_data[0];
                        send = (bsr_pos == 3'd2);
                        beep = (bsr_pos == 3'd3);
                    end
                end
                default: begin
                end
            endcase
        end else begin
            unique case (req.port_address)
                PORT_MASK:     rd = (mask_reg & MASK_RD_MASK) | {req.fm_mask_in, 7'b0};
                PORT_STROBE:   rd = STROBE_RD_BASE | {2'b00, req.vsync_flag,
                                    req.calendar_in, 2'b00, ~req.crt_low_freq, 1'b0};
                PORT_MODE_LO:  rd = mode_sw_reg[7:0];
                PORT_MODE_HI:  rd = mode_sw_reg[15:8];
                PORT_AUDIO:    rd = audio_reg;
                PORT_STATUS_A: rd = status_a_reg;
                PORT_SERIAL:   rd = {4'b0000, req.crt_low_freq, 3'b000} | req.serial_status;
                PORT_CTRL_C:   rd = ctrl_c_reg;
                default:       rd = UNMAPPED_RD;
            endcase
        end
    end

    // levels reflect state after this item
    assign lamp_raw = ctrl_c_next[6:4];

    always_comb begin
        res.read_data           = rd;
        res.calendar_lines      = {calendar_next[3], strobe_next[2:1], calendar_next[2:0]};
        res.calendar_update     = cal_up;
        res.fm_mask_value       = mask_next[7];
        res.fm_mask_update      = fm_up;
        res.mouse_strobe        = strobe_next[6];
        res.mouse_strobe_update = ms_up;
        res.serial_send         = send;
        res.beep_update         = beep;
        res.led_state           = (lamp_raw == 3'b111) ? 3'b111 : ~lamp_raw;
        res.port_c_low          = ctrl_c_next[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calendar_reg <= 8'h00;
            mask_reg     <= 8'h00;
            strobe_reg   <= 8'h00;
            audio_reg    <= AUDIO_RESET;
            mode_sw_reg  <= 16'h0000;
            status_a_reg <= STATUS_A_RESET;
            ctrl_c_reg   <= CTRL_C_RESET;
        end else if (en) begin
            calendar_reg <= calendar_next;
            mask_reg     <= mask_next;
            strobe_reg   <= strobe_next;
            audio_reg    <= audio_next;
            mode_sw_reg  <= mode_sw_next;
            status_a_reg <= status_a_next;
            ctrl_c_reg   <= ctrl_c_next;
        end
    end

    assign mode_sw_legal = (mode_sw_reg == 16'h0000) || (mode_sw_reg == MODE_SW_SET)
                           || (mode_sw_reg == MODE_SW_CLR);

    `SPR_ASSERT_ALWAYS(a_audio_masked, aclk, aresetn, (audio_reg & ~AUDIO_MASK) == 8'h00)
    `SPR_ASSERT_ALWAYS(a_mask_bit6_clear, aclk, aresetn, mask_reg[6] == 1'b0)
    `SPR_ASSERT_ALWAYS(a_mode_sw_legal, aclk, aresetn, mode_sw_legal)
    `SPR_ASSERT_NEXT(a_read_keeps_c, aclk, aresetn, !(en && wr), $stable(ctrl_c_reg))

endmodule

`default_nettype wire

@@ rtl/system_port_register_bank_unit.sv @@
// top level of the system-port register bank: input and result registers
// depends on spr_pkg and spr_bank
//
// usage:
//   one i/o access per item on the s_ channel; s_tuser carries the access
//   kind (0 read, 1 write), s_tdata the address, write byte and the outside
//   status inputs. every item gives exactly one result item on the m_
//   channel with the read byte, the driven levels and the update pulses.
//   an accepted item passes through the input register and then the result
//   register. throughput: one item per cycle while the receiver does not
//   stall; the bank state is updated as the item moves from the input
//   register into the result register.
//   when the receiver stalls, the result register holds and the input
//   register still takes one further item; s_tready drops only while both
//   are full and m_tready is low.
//   reset (aresetn low, synchronous) empties both registers and loads the
//   bank reset values; no clearing pass is needed.
`default_nettype none

module system_port_register_bank_unit
    import spr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // fields from bit 0: port_address[8:0], write_data[16:9], vsync_flag[17],
    // calendar_in[18], crt_low_freq[19], serial_status[27:20], fm_mask_in[28]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // fields from bit 0: kind[0]
    input  wire logic                   s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // fields from bit 0: read_data[7:0], calendar_lines[13:8], calendar_update[14],
    // fm_mask_value[15], fm_mask_update[16], mouse_strobe[17],
    // mouse_strobe_update[18], serial_send[19], beep_update[20], led_state[23:21],
    // port_c_low[27:24]
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    logic     in_valid_reg;
    spr_req_t in_req_reg;
    logic     out_valid_reg;
    spr_res_t out_res_reg;
    spr_res_t bank_res;
    spr_req_t s_req;
    logic     advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        s_req.kind          = s_tuser;
        s_req.port_address  = s_tdata[8:0];
        s_req.write_data    = s_tdata[16:9];
        s_req.vsync_flag    = s_tdata[17];
        s_req.calendar_in   = s_tdata[18];
        s_req.crt_low_freq  = s_tdata[19];
        s_req.serial_status = s_tdata[27:20];
        s_req.fm_mask_in    = s_tdata[28];
    end

    spr_bank u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .req     (in_req_reg),
        .res     (bank_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tready && s_tvalid) begin
            in_req_reg <= s_req;
        end
        if (advance) begin
            out_res_reg <= bank_res;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata        = '0;
        m_tdata[7:0]   = out_res_reg.read_data;
        m_tdata[13:8]  = out_res_reg.calendar_lines;
        m_tdata[14]    = out_res_reg.calendar_update;
        m_tdata[15]    = out_res_reg.fm_mask_value;
        m_tdata[16]    = out_res_reg.fm_mask_update;
        m_tdata[17]    = out_res_reg.mouse_strobe;
        m_tdata[18]    = out_res_reg.mouse_strobe_update;
        m_tdata[19]    = out_res_reg.serial_send;
        m_tdata[20]    = out_res_reg.beep_update;
        m_tdata[23:21] = out_res_reg.led_state;
        m_tdata[27:24] = out_res_reg.port_c_low;
    end

endmodule

`default_nettype wire
